// File: hw/rtl/rstm_pkg.sv
// Shared types and constants for the relay switch time meter.
// Depends on nothing; the top, front, back and testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rstm_pkg;

  localparam int TIME_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int DELAY_W = 32;
  localparam int RUN_W   = 8;
  localparam int TOTAL_W = 40;
  localparam int FRAC_W  = 8;
  localparam int AVG_W   = TOTAL_W + FRAC_W;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] REG_OPEN_STABLE = 2'd1;
  localparam logic [1:0] REG_RUN_COUNT   = 2'd2;

  localparam logic [31:0]      DEBOUNCE_RST    = 32'd2000;
  localparam logic [31:0]      OPEN_STABLE_RST = 32'd100000;
  localparam logic [RUN_W-1:0] RUN_COUNT_RST   = 8'd10;

  typedef enum logic [3:0] {
    PH_WAIT_OPEN    = 4'b0001,
    PH_WAIT_CLOSE   = 4'b0010,
    PH_WAIT_OPENING = 4'b0100,
    PH_FINISHED     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [31:0]      debounce_us;
    logic [31:0]      open_stable_us;
    logic [RUN_W-1:0] run_count;
  } cfg_t;

  // One classified sample, handed from the front to the back.
  typedef struct packed {
    logic               relay_on;
    logic               report_valid;
    logic [RUN_W-1:0]   run_number;
    logic [DELAY_W-1:0] close_delay_us;
    logic [DELAY_W-1:0] open_delay_us;
    logic               all_done;
    logic               start_avg;
    logic [TOTAL_W-1:0] close_total;
    logic [TOTAL_W-1:0] open_total;
  } job_t;

  // One result beat as shown on the output ports.
  typedef struct packed {
    logic               relay_on;
    logic               report_valid;
    logic [RUN_W-1:0]   run_number;
    logic [DELAY_W-1:0] close_delay_us;
    logic [DELAY_W-1:0] open_delay_us;
    logic               all_done;
    logic [AVG_W-1:0]   avg_close_q8;
    logic [AVG_W-1:0]   avg_open_q8;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/relay_switch_time_meter_top.sv
// Top level of the relay switch time meter: configuration registers and the
// front, queue and back. Depends on rstm_pkg, rstm_front, rstm_fifo and rstm_back.
//
// Usage. Each input beat is one contact sample (time_us, contact_level), pushed
// with push while full is low. Every sample yields exactly one result beat, read
// with pop while empty is low, oldest first. The result carries the relay drive,
// and on the sample that confirms an opening edge the close and open delays.
// The front classifies one sample per cycle while full is low and writes it
// into a short queue; the back moves it into the result register. Empty falls
// once the sample has passed the queue and reached the result register, and
// samples keep flowing at one per cycle while the reader pops and no average
// is being divided. The sample that completes the last run starts two 48-step
// divisions for the Q.8 averages; that one result waits for the bit-serial
// dividers, and meanwhile the queue fills and full rises. After that the block
// repeats the averages with all_done set and the relay off.
// When the reader stalls, the result register holds and the queue takes
// further samples until full, then full holds the writer off; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and result register, puts
// the registers at their defaults and waits for an open contact.
// Configuration is written over the APB port at byte addresses 0, 4 and 8.
// The user writes it only while no sample is in flight; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module relay_switch_time_meter_top #(
  parameter int TIME_BITS   = rstm_pkg::TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = rstm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] in_time_us,
  input  wire logic        in_contact_level,
  // Result channel.
  output logic             empty,
  input  wire logic        pop,
  output logic             out_relay_on,
  output logic             out_report_valid,
  output logic [7:0]       out_run_number,
  output logic [31:0]      out_close_delay_us,
  output logic [31:0]      out_open_delay_us,
  output logic             out_all_done,
  output logic [47:0]      out_avg_close_q8,
  output logic [47:0]      out_avg_open_q8,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rstm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rstm_pkg::DATA_W-1:0]   pwdata,
  output logic      [rstm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int JOB_W = $bits(rstm_pkg::job_t);

  rstm_pkg::cfg_t cfg_r;
  rstm_pkg::job_t job_in, job_out;
  rstm_pkg::res_t res;
  logic           in_take, q_empty, job_take, out_valid;
  logic [1:0]     reg_idx;
  logic [JOB_W-1:0] q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign in_take = push && !full;

  // Registers are written in the access phase; pready never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_us    <= rstm_pkg::DEBOUNCE_RST;
      cfg_r.open_stable_us <= rstm_pkg::OPEN_STABLE_RST;
      cfg_r.run_count      <= rstm_pkg::RUN_COUNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        rstm_pkg::REG_DEBOUNCE:    cfg_r.debounce_us    <= pwdata;
        rstm_pkg::REG_OPEN_STABLE: cfg_r.open_stable_us <= pwdata;
        rstm_pkg::REG_RUN_COUNT:   cfg_r.run_count      <= pwdata[rstm_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rstm_pkg::REG_DEBOUNCE:    prdata = cfg_r.debounce_us;
      rstm_pkg::REG_OPEN_STABLE: prdata = cfg_r.open_stable_us;
      rstm_pkg::REG_RUN_COUNT:   prdata = rstm_pkg::DATA_W'(cfg_r.run_count);
      default:                   prdata = '0;
    endcase
  end

  rstm_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (in_take),
    .time_us       (in_time_us),
    .contact_level (in_contact_level),
    .job           (job_in)
  );

  rstm_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_take),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign job_out = rstm_pkg::job_t'(q_rdata);

  rstm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_avail (!q_empty),
    .job_take  (job_take),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res)
  );

  assign empty              = !out_valid;
  assign out_relay_on       = res.relay_on;
  assign out_report_valid   = res.report_valid;
  assign out_run_number     = res.run_number;
  assign out_close_delay_us = res.close_delay_us;
  assign out_open_delay_us  = res.open_delay_us;
  assign out_all_done       = res.all_done;
  assign out_avg_close_q8   = res.avg_close_q8;
  assign out_avg_open_q8    = res.avg_open_q8;

endmodule

`default_nettype wire

// File: hw/rtl/rstm_fifo.sv
// Short register queue between the front and the back of the relay switch time meter.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module rstm_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rstm_div.sv
// Restoring divider, one quotient bit per cycle, for the Q.8 averages.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module rstm_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r, den_r, rem_step;
  logic [DEN_W:0]   trial;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r, fits;

  // The dividend shifts out of the top of quot_r while quotient bits shift in.
  assign trial    = {rem_r, quot_r[NUM_W-1]};
  assign fits     = (trial >= {1'b0, den_r});
  assign rem_step = fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  assign done     = done_r;
  assign quot     = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[NUM_W-2:0], fits};
      rem_r  <= rem_step;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rstm_front.sv
// Front of the relay switch time meter: edge debounce, run phases and totals.
// Depends on rstm_pkg for the configuration, phase and job types.
`timescale 1ns / 1ps
`default_nettype none

module rstm_front #(
  parameter int TIME_BITS = rstm_pkg::TIME_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rstm_pkg::cfg_t    cfg,
  input  wire logic              accept,
  input  wire logic [31:0]       time_us,
  input  wire logic              contact_level,
  output rstm_pkg::job_t         job
);

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef logic [TIME_BITS-1:0] tm_t;

  rstm_pkg::phase_t phase_r, phase_nxt;
  logic prev_level_r, prev_level_nxt;
  logic osv_r, osv_nxt;
  logic ep_r, ep_nxt;
  logic relay_r, relay_nxt;
  tm_t  open_since_r, open_since_nxt;
  tm_t  edge_time_r, edge_time_nxt;
  tm_t  last_edge_r, last_edge_nxt;
  tm_t  cmd_time_r, cmd_time_nxt;
  logic [rstm_pkg::DELAY_W-1:0] close_delay_r, close_delay_nxt;
  logic [rstm_pkg::TOTAL_W-1:0] close_total_r, close_total_nxt;
  logic [rstm_pkg::TOTAL_W-1:0] open_total_r, open_total_nxt;
  logic [rstm_pkg::RUN_W-1:0]   runs_r, runs_nxt;

  tm_t  now;
  logic edge_new, conf_ok, report;
  logic [rstm_pkg::RUN_W-1:0]   target;
  logic [rstm_pkg::DELAY_W-1:0] open_delay;

  function automatic tm_t tdiff(input tm_t a, input tm_t b);
    return a - b;
  endfunction

  function automatic logic reached(input tm_t diff, input logic [31:0] lim);
    return CMP_W'(diff) >= CMP_W'(lim);
  endfunction

  always_comb begin
    now             = TIME_BITS'(time_us);
    target          = (cfg.run_count == '0) ? rstm_pkg::RUN_W'(1) : cfg.run_count;
    phase_nxt       = phase_r;
    prev_level_nxt  = prev_level_r;
    osv_nxt         = osv_r;
    ep_nxt          = ep_r;
    relay_nxt       = relay_r;
    open_since_nxt  = open_since_r;
    edge_time_nxt   = edge_time_r;
    last_edge_nxt   = last_edge_r;
    cmd_time_nxt    = cmd_time_r;
    close_delay_nxt = close_delay_r;
    close_total_nxt = close_total_r;
    open_total_nxt  = open_total_r;
    runs_nxt        = runs_r;
    edge_new        = 1'b0;
    conf_ok         = 1'b0;
    report          = 1'b0;
    open_delay      = '0;

    if (phase_r != rstm_pkg::PH_FINISHED) begin
      if ((contact_level != prev_level_r) && !ep_r &&
          reached(tdiff(now, last_edge_r), cfg.debounce_us)) begin
        edge_new      = 1'b1;
        edge_time_nxt = now;
        last_edge_nxt = now;
        ep_nxt        = 1'b1;
      end
      prev_level_nxt = contact_level;

      // An edge taken in this very sample is zero microseconds old.
      conf_ok = ep_nxt && (edge_new ? (cfg.debounce_us == '0)
                                    : reached(tdiff(now, edge_time_r), cfg.debounce_us));

      unique case (phase_r)
        rstm_pkg::PH_WAIT_OPEN: begin
          if (contact_level) begin
            if (!osv_r) begin
              open_since_nxt = now;
              osv_nxt        = 1'b1;
            end
            if (osv_r ? reached(tdiff(now, open_since_r), cfg.open_stable_us)
                      : (cfg.open_stable_us == '0)) begin
              ep_nxt       = 1'b0;
              phase_nxt    = rstm_pkg::PH_WAIT_CLOSE;
              cmd_time_nxt = now;
              relay_nxt    = 1'b1;
            end
          end else begin
            osv_nxt = 1'b0;
          end
        end
        rstm_pkg::PH_WAIT_CLOSE: begin
          if (conf_ok) begin
            ep_nxt = 1'b0;
            if (!contact_level) begin
              close_delay_nxt = rstm_pkg::DELAY_W'(tdiff(edge_time_nxt, cmd_time_r));
              phase_nxt       = rstm_pkg::PH_WAIT_OPENING;
              cmd_time_nxt    = now;
              relay_nxt       = 1'b0;
            end
          end
        end
        rstm_pkg::PH_WAIT_OPENING: begin
          if (conf_ok) begin
            if (!contact_level) begin
              ep_nxt = 1'b0;
            end else begin
              open_delay      = rstm_pkg::DELAY_W'(tdiff(edge_time_nxt, cmd_time_r));
              close_total_nxt = close_total_r + rstm_pkg::TOTAL_W'(close_delay_r);
              open_total_nxt  = open_total_r + rstm_pkg::TOTAL_W'(open_delay);
              runs_nxt        = runs_r + rstm_pkg::RUN_W'(1);
              osv_nxt         = 1'b0;
              report          = 1'b1;
              if (runs_nxt >= target) begin
                relay_nxt = 1'b0;
                phase_nxt = rstm_pkg::PH_FINISHED;
              end else begin
                phase_nxt = rstm_pkg::PH_WAIT_OPEN;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    job.relay_on       = relay_nxt;
    job.report_valid   = report;
    job.run_number     = runs_nxt;
    job.close_delay_us = report ? close_delay_r : '0;
    job.open_delay_us  = open_delay;
    job.all_done       = (phase_nxt == rstm_pkg::PH_FINISHED);
    job.start_avg      = (phase_nxt == rstm_pkg::PH_FINISHED) &&
                         (phase_r != rstm_pkg::PH_FINISHED);
    job.close_total    = close_total_nxt;
    job.open_total     = open_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rstm_pkg::PH_WAIT_OPEN;
      prev_level_r  <= 1'b1;
      osv_r         <= 1'b0;
      ep_r          <= 1'b0;
      relay_r       <= 1'b0;
      open_since_r  <= '0;
      edge_time_r   <= '0;
      last_edge_r   <= '0;
      cmd_time_r    <= '0;
      close_delay_r <= '0;
      close_total_r <= '0;
      open_total_r  <= '0;
      runs_r        <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      prev_level_r  <= prev_level_nxt;
      osv_r         <= osv_nxt;
      ep_r          <= ep_nxt;
      relay_r       <= relay_nxt;
      open_since_r  <= open_since_nxt;
      edge_time_r   <= edge_time_nxt;
      last_edge_r   <= last_edge_nxt;
      cmd_time_r    <= cmd_time_nxt;
      close_delay_r <= close_delay_nxt;
      close_total_r <= close_total_nxt;
      open_total_r  <= open_total_nxt;
      runs_r        <= runs_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rstm_back.sv
// Back of the relay switch time meter: result register and the average division.
// Depends on rstm_pkg for the job and result types and on rstm_div.
`timescale 1ns / 1ps
`default_nettype none

module rstm_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rstm_pkg::job_t job,
  input  wire logic           job_avail,
  output logic                job_take,
  input  wire logic           pop,
  output logic                out_valid,
  output rstm_pkg::res_t      res
);

  logic                          out_valid_r, busy_r, slot_free, div_start, div_done;
  logic                          done_c, done_o;
  rstm_pkg::res_t                res_r;
  rstm_pkg::job_t                held_r;
  logic [rstm_pkg::AVG_W-1:0]    avg_close_r, avg_open_r, quot_c, quot_o, num_c, num_o;

  assign slot_free = !out_valid_r || pop;
  assign job_take  = job_avail && slot_free && !busy_r;
  assign div_start = job_take && job.start_avg;
  assign div_done  = done_c && done_o;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // Rounded half up: add half the divisor before dividing.
  assign num_c = {job.close_total, rstm_pkg::FRAC_W'(0)} +
                 rstm_pkg::AVG_W'(job.run_number >> 1);
  assign num_o = {job.open_total, rstm_pkg::FRAC_W'(0)} +
                 rstm_pkg::AVG_W'(job.run_number >> 1);

  rstm_div #(.NUM_W(rstm_pkg::AVG_W), .DEN_W(rstm_pkg::RUN_W)) u_div_close (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_c),
    .den   (job.run_number),
    .done  (done_c),
    .quot  (quot_c)
  );

  rstm_div #(.NUM_W(rstm_pkg::AVG_W), .DEN_W(rstm_pkg::RUN_W)) u_div_open (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_o),
    .den   (job.run_number),
    .done  (done_o),
    .quot  (quot_o)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else if (job_take) begin
      if (job.start_avg) begin
        busy_r      <= 1'b1;
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (busy_r && div_done) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && job.start_avg) begin
      held_r <= job;
    end
    if (job_take && !job.start_avg) begin
      res_r.relay_on       <= job.relay_on;
      res_r.report_valid   <= job.report_valid;
      res_r.run_number     <= job.run_number;
      res_r.close_delay_us <= job.close_delay_us;
      res_r.open_delay_us  <= job.open_delay_us;
      res_r.all_done       <= job.all_done;
      res_r.avg_close_q8   <= job.all_done ? avg_close_r : '0;
      res_r.avg_open_q8    <= job.all_done ? avg_open_r : '0;
    end else if (busy_r && div_done) begin
      res_r.relay_on       <= held_r.relay_on;
      res_r.report_valid   <= held_r.report_valid;
      res_r.run_number     <= held_r.run_number;
      res_r.close_delay_us <= held_r.close_delay_us;
      res_r.open_delay_us  <= held_r.open_delay_us;
      res_r.all_done       <= held_r.all_done;
      res_r.avg_close_q8   <= quot_c;
      res_r.avg_open_q8    <= quot_o;
      avg_close_r          <= quot_c;
      avg_open_r           <= quot_o;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rstm_checker.sv
// Port-level checks for the relay switch time meter, bound to the top level.
// Depends only on the ports of relay_switch_time_meter_top.
`timescale 1ns / 1ps
`default_nettype none

module rstm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        out_relay_on,
  input wire logic        out_report_valid,
  input wire logic [7:0]  out_run_number,
  input wire logic [31:0] out_close_delay_us,
  input wire logic [31:0] out_open_delay_us,
  input wire logic        out_all_done,
  input wire logic [47:0] out_avg_close_q8,
  input wire logic [47:0] out_avg_open_q8
);

  // Once all runs are done the relay stays de-energized.
  a_done_relay_off: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_all_done |-> !out_relay_on)
    else $error("relay energized after all runs completed");

  // Delays are only carried by a beat that finished a measurement.
  a_delays_need_report: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_report_valid |-> out_close_delay_us == 32'd0 && out_open_delay_us == 32'd0)
    else $error("delay fields nonzero without a report");

  // Averages are zero until the block has finished.
  a_avg_need_done: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_all_done |-> out_avg_close_q8 == 48'd0 && out_avg_open_q8 == 48'd0)
    else $error("average fields nonzero before completion");

  // Reset leaves the result side empty and the input queue not full.
  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> empty && !full)
    else $error("queues not empty after reset");

  // A waiting result is not withdrawn, nor its run number changed, before it is popped.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_run_number))
    else $error("waiting result dropped or changed");

endmodule

bind relay_switch_time_meter_top rstm_checker u_rstm_checker (.*);

`default_nettype wire

// File: tb/sv/relay_switch_time_meter_top_tb.sv
// Self-checking testbench for relay_switch_time_meter_top: drives contact samples,
// writes the APB registers and checks every result beat against its own predictor.
// Depends on rstm_pkg and relay_switch_time_meter_top.
`timescale 1ns / 1ps

module relay_switch_time_meter_top_tb;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_GAP        = 17;
  // The block passes each sample through the queue into the result register,
  // and the averaging beat waits on the dividers. Idle waits are sized from that.
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 120;

  logic                        clk;
  logic                        rst_n;
  logic                        push;
  logic                        full;
  logic [31:0]                 in_time_us;
  logic                        in_contact_level;
  logic                        empty;
  logic                        pop;
  logic                        out_relay_on;
  logic                        out_report_valid;
  logic [7:0]                  out_run_number;
  logic [31:0]                 out_close_delay_us;
  logic [31:0]                 out_open_delay_us;
  logic                        out_all_done;
  logic [47:0]                 out_avg_close_q8;
  logic [47:0]                 out_avg_open_q8;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rstm_pkg::ADDR_W-1:0] paddr;
  logic [rstm_pkg::DATA_W-1:0] pwdata;
  logic [rstm_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  relay_switch_time_meter_top dut (.*);

  // Predictor state: a private copy of the registers and of the meter's
  // measurement state, advanced once per accepted sample.
  rstm_pkg::cfg_t   meter_cfg;
  rstm_pkg::phase_t m_phase;
  logic        m_prev_level;
  logic        m_open_ok;
  logic        m_edge_wait;
  logic        m_relay;
  logic [31:0] m_open_start;
  logic [31:0] m_edge_at;
  logic [31:0] m_last_edge;
  logic [31:0] m_cmd_at;
  logic [31:0] m_close_us;
  logic [39:0] m_close_sum;
  logic [39:0] m_open_sum;
  logic [7:0]  m_runs;

  // Result beats still owed by the block, oldest first.
  rstm_pkg::res_t expected_meter_beats[$];
  int   mismatch_count;
  int   stall_cycles;

  // Knobs shared by the sender, the receiver and the test tasks.
  bit   tx_gaps;
  bit   rx_gaps;
  int   rx_hold_request;

  // State of the simulated relay contact that produces the random samples.
  logic [31:0] stim_time;
  logic        sim_relay_seen;
  int          sim_settle;

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void meter_reset();
    meter_cfg.debounce_us    = rstm_pkg::DEBOUNCE_RST;
    meter_cfg.open_stable_us = rstm_pkg::OPEN_STABLE_RST;
    meter_cfg.run_count      = rstm_pkg::RUN_COUNT_RST;
    m_phase      = rstm_pkg::PH_WAIT_OPEN;
    m_prev_level = 1'b1;
    m_open_ok    = 1'b0;
    m_edge_wait  = 1'b0;
    m_relay      = 1'b0;
    m_open_start = '0;
    m_edge_at    = '0;
    m_last_edge  = '0;
    m_cmd_at     = '0;
    m_close_us   = '0;
    m_close_sum  = '0;
    m_open_sum   = '0;
    m_runs       = '0;
  endfunction

  // A pending edge is confirmed once the debounce time has passed and the
  // level matches; on a mismatch at that point the edge is thrown away.
  function automatic bit edge_confirmed(input logic [31:0] now, input logic lvl,
                                        input logic want);
    logic [31:0] age;
    age = now - m_edge_at;
    if (!m_edge_wait || age < meter_cfg.debounce_us) return 1'b0;
    if (lvl != want) begin
      m_edge_wait = 1'b0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mean of a 40-bit total in Q.8, rounded half up; zero runs count as one.
  function automatic logic [47:0] q8_mean(input logic [39:0] sum, input logic [7:0] n);
    logic [63:0] d;
    logic [63:0] num;
    d   = (n == 8'd0) ? 64'd1 : {56'd0, n};
    num = ({24'd0, sum} << 8) + d / 2;
    return 48'(num / d);
  endfunction

  // Advances the predictor by one sample and returns the beat it must cause.
  // The edge detector sees the sample first, then the phase logic.
  function automatic rstm_pkg::res_t meter_predict(input logic [31:0] now, input logic lvl);
    rstm_pkg::res_t r;
    logic [31:0] since_edge;
    logic [31:0] open_for;
    logic [31:0] open_us;
    logic [7:0]  goal;
    logic        report;
    open_us = '0;
    report  = 1'b0;
    goal    = (meter_cfg.run_count == 8'd0) ? 8'd1 : meter_cfg.run_count;
    if (m_phase != rstm_pkg::PH_FINISHED) begin
      since_edge = now - m_last_edge;
      if (lvl != m_prev_level && !m_edge_wait && since_edge >= meter_cfg.debounce_us) begin
        m_edge_at   = now;
        m_last_edge = now;
        m_edge_wait = 1'b1;
      end
      m_prev_level = lvl;
      unique case (m_phase)
        rstm_pkg::PH_WAIT_OPEN: begin
          if (lvl) begin
            if (!m_open_ok) begin
              m_open_start = now;
              m_open_ok    = 1'b1;
            end
            open_for = now - m_open_start;
            if (open_for >= meter_cfg.open_stable_us) begin
              m_edge_wait = 1'b0;
              m_phase     = rstm_pkg::PH_WAIT_CLOSE;
              m_cmd_at    = now;
              m_relay     = 1'b1;
            end
          end else begin
            m_open_ok = 1'b0;
          end
        end
        rstm_pkg::PH_WAIT_CLOSE: begin
          if (edge_confirmed(now, lvl, 1'b0)) begin
            m_close_us  = m_edge_at - m_cmd_at;
            m_edge_wait = 1'b0;
            m_phase     = rstm_pkg::PH_WAIT_OPENING;
            m_cmd_at    = now;
            m_relay     = 1'b0;
          end
        end
        rstm_pkg::PH_WAIT_OPENING: begin
          if (edge_confirmed(now, lvl, 1'b1)) begin
            open_us     = m_edge_at - m_cmd_at;
            m_close_sum = m_close_sum + {8'd0, m_close_us};
            m_open_sum  = m_open_sum + {8'd0, open_us};
            m_runs      = m_runs + 8'd1;
            m_open_ok   = 1'b0;
            report      = 1'b1;
            if (m_runs >= goal) begin
              m_relay = 1'b0;
              m_phase = rstm_pkg::PH_FINISHED;
            end else begin
              m_phase = rstm_pkg::PH_WAIT_OPEN;
            end
          end
        end
        default: ;
      endcase
    end
    r.relay_on       = m_relay;
    r.report_valid   = report;
    r.run_number     = m_runs;
    r.close_delay_us = report ? m_close_us : 32'd0;
    r.open_delay_us  = report ? open_us : 32'd0;
    r.all_done       = (m_phase == rstm_pkg::PH_FINISHED);
    r.avg_close_q8   = r.all_done ? q8_mean(m_close_sum, m_runs) : 48'd0;
    r.avg_open_q8    = r.all_done ? q8_mean(m_open_sum, m_runs) : 48'd0;
    return r;
  endfunction

  function automatic int pick_gap(input bit enabled);
    return enabled ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  // Sends one sample beat. The task returns at the clock edge that accepted it,
  // leaving push high so that a following beat can go out without a bubble.
  task automatic send_sample(input logic [31:0] stamp, input logic lvl);
    int gap;
    gap = pick_gap(tx_gaps);
    if (gap > 0) begin
      if (push) push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push             <= 1'b1;
    in_time_us       <= stamp;
    in_contact_level <= lvl;
    do @(posedge clk); while (full !== 1'b0);
    expected_meter_beats.push_back(meter_predict(stamp, lvl));
  endtask

  // Stops sending and waits until every owed result beat has been taken,
  // then lets the block settle before anything else happens.
  task automatic wait_meter_idle();
    if (push) push <= 1'b0;
    while (expected_meter_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then the bus is left idle.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      rstm_pkg::REG_DEBOUNCE:    meter_cfg.debounce_us    = value;
      rstm_pkg::REG_OPEN_STABLE: meter_cfg.open_stable_us = value;
      rstm_pkg::REG_RUN_COUNT:   meter_cfg.run_count      = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Time advance per sample, scaled so that debounce and open windows span
  // a handful of samples with the current settings.
  function automatic int step_bound();
    logic [33:0] s;
    s = ({2'b00, meter_cfg.debounce_us} + {2'b00, meter_cfg.open_stable_us}) / 6 + 1;
    return (s > 34'd5000) ? 5000 : int'(s);
  endfunction

  // One sample from a simulated relay: the contact follows the coil after a
  // few bouncing samples, with occasional single-sample glitches and rare
  // jumps of the timestamp to anywhere in its range.
  task automatic drive_relay_sample();
    logic lvl;
    if (m_relay !== sim_relay_seen) begin
      sim_relay_seen = m_relay;
      sim_settle     = $urandom_range(0, 6);
    end
    if (sim_settle > 0) begin
      sim_settle--;
      lvl = 1'($urandom_range(0, 1));
    end else begin
      lvl = !m_relay;
    end
    if ($urandom_range(0, 15) == 0) lvl = !lvl;
    if ($urandom_range(0, 63) == 0) stim_time = $urandom;
    else stim_time = stim_time + $urandom_range(1, step_bound());
    send_sample(stim_time, lvl);
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_meter_beat();
    rstm_pkg::res_t want;
    if (expected_meter_beats.size() == 0) begin
      $error("result beat with no sample waiting for it, run_number %0d", out_run_number);
      mismatch_count++;
    end else begin
      want = expected_meter_beats.pop_front();
      compare_field("relay_on", 64'(want.relay_on), 64'(out_relay_on));
      compare_field("report_valid", 64'(want.report_valid), 64'(out_report_valid));
      compare_field("run_number", 64'(want.run_number), 64'(out_run_number));
      compare_field("close_delay_us", 64'(want.close_delay_us), 64'(out_close_delay_us));
      compare_field("open_delay_us", 64'(want.open_delay_us), 64'(out_open_delay_us));
      compare_field("all_done", 64'(want.all_done), 64'(out_all_done));
      compare_field("avg_close_q8", 64'(want.avg_close_q8), 64'(out_avg_close_q8));
      compare_field("avg_open_q8", 64'(want.avg_open_q8), 64'(out_avg_open_q8));
    end
  endtask

  // Result side. Each beat is preceded by a random wait; a long hold asked
  // for by a test is counted out here, in the receiver's own process.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pick_gap(rx_gaps);
      if (rx_hold_request > 0) begin
        if (pop) pop <= 1'b0;
        repeat (rx_hold_request) @(posedge clk);
        rx_hold_request = 0;
      end
      if (gap > 0) begin
        if (pop) pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      check_meter_beat();
    end
  end

  // Watchdog: a long stretch with no beat moving on either side means the
  // block has hung.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Hand-built samples under the reset settings: an edge that goes pending
  // while waiting for an open contact and is cleared when the run starts,
  // timestamps at zero and at the top of the range, a pending close edge
  // dropped because the level bounced back, then a clean close and open.
  task automatic test_directed_edges();
    send_sample(32'd0, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'd100, 1'b1);
    send_sample(32'd100_100, 1'b1);
    send_sample(32'd102_000, 1'b0);
    send_sample(32'd103_000, 1'b1);
    send_sample(32'd104_000, 1'b1);
    send_sample(32'd105_000, 1'b0);
    send_sample(32'd107_000, 1'b0);
    send_sample(32'd109_000, 1'b1);
    send_sample(32'd111_000, 1'b1);
  endtask

  // Register extremes. With zero debounce and zero open time a run takes three
  // samples. With both at all ones, each step only happens when the wrapped
  // distance is exactly the largest value, so the timestamps step backward.
  task automatic test_extreme_settings();
    wait_meter_idle();
    cfg_write(rstm_pkg::REG_DEBOUNCE, 32'd0);
    cfg_write(rstm_pkg::REG_OPEN_STABLE, 32'd0);
    cfg_write(rstm_pkg::REG_RUN_COUNT, 32'd255);
    send_sample(32'h0000_5000, 1'b1);
    send_sample(32'h0000_5001, 1'b0);
    send_sample(32'h0000_5002, 1'b1);
    wait_meter_idle();
    cfg_write(rstm_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF);
    cfg_write(rstm_pkg::REG_OPEN_STABLE, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'hFFFF_FFFE, 1'b1);
    send_sample(m_last_edge - 32'd1, 1'b0);
    send_sample(m_edge_at - 32'd1, 1'b0);
    send_sample(m_last_edge - 32'd1, 1'b1);
    send_sample(m_edge_at - 32'd1, 1'b1);
  endtask

  // Random phases, each under fresh settings written while the block is
  // idle. One phase runs without any idling on either side.
  task automatic test_random_runs();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_meter_idle();
      cfg_write(rstm_pkg::REG_DEBOUNCE, (p == 0) ? 32'd0 : $urandom_range(1, 40));
      cfg_write(rstm_pkg::REG_OPEN_STABLE, $urandom_range(0, 300));
      cfg_write(rstm_pkg::REG_RUN_COUNT, (p == 0) ? 32'd255 : $urandom_range(128, 255));
      tx_gaps = (p != 2);
      rx_gaps = (p != 2);
      repeat (PHASE_SAMPLES) drive_relay_sample();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // The receiver holds off for a long stretch while samples keep coming
  // back to back, so the queue fills and full holds the sender; afterwards
  // the sender pauses until every owed beat has been taken.
  task automatic test_backpressure();
    rx_hold_request = HOLD_CYCLES;
    tx_gaps         = 1'b0;
    repeat (40) drive_relay_sample();
    tx_gaps = 1'b1;
    wait_meter_idle();
  endtask

  // A run count of zero counts as one and is already below the completed
  // runs, so the next completed run ends the measurement and the averages
  // come out. After that, samples and register writes change nothing.
  task automatic test_finish_and_idle();
    int n;
    wait_meter_idle();
    cfg_write(rstm_pkg::REG_RUN_COUNT, 32'd0);
    n = 0;
    while (m_phase != rstm_pkg::PH_FINISHED && n < 600) begin
      drive_relay_sample();
      n++;
    end
    repeat (20) drive_relay_sample();
    wait_meter_idle();
    cfg_write(rstm_pkg::REG_RUN_COUNT, 32'd1);
    cfg_write(rstm_pkg::REG_DEBOUNCE, $urandom);
    cfg_write(rstm_pkg::REG_OPEN_STABLE, $urandom);
    repeat (20) drive_relay_sample();
  endtask

  initial begin
    meter_reset();
    mismatch_count   = 0;
    tx_gaps          = 1'b1;
    rx_gaps          = 1'b1;
    rx_hold_request  = 0;
    stim_time        = $urandom;
    sim_relay_seen   = 1'b0;
    sim_settle       = 0;
    rst_n            = 1'b0;
    push             = 1'b0;
    in_time_us       = '0;
    in_contact_level = 1'b1;
    pop              = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_extreme_settings();
    test_random_runs();
    test_backpressure();
    test_finish_and_idle();

    // Drain, then give the block time to show any stray beat.
    wait_meter_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_meter_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
